[sv/vafc_pkg.sv]
// ----------------------------------------------------------------------------
// vafc_pkg
// Shared types, codes and helper functions of the vertex attribute converter.
// ----------------------------------------------------------------------------
package vafc_pkg;

    localparam int RawW    = 64;
    localparam int ResultW = 32;
    localparam int CfgIdxW = 2;
    localparam int CfgDataW = 3;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_COMPONENT_TYPE = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_NORMALIZED     = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_RESULT_FORMAT  = 2'd2;

    typedef enum logic [2:0] {
        CT_S8  = 3'd0,
        CT_U8  = 3'd1,
        CT_S16 = 3'd2,
        CT_U16 = 3'd3,
        CT_S32 = 3'd4,
        CT_U32 = 3'd5,
        CT_F32 = 3'd6,
        CT_F64 = 3'd7
    } comp_type_t;

    localparam logic FMT_FLOAT = 1'b0;
    localparam logic FMT_UINT  = 1'b1;

    localparam logic [31:0] F32_ONE     = 32'h3F80_0000;
    localparam logic [31:0] F32_INF     = 32'h7F80_0000;
    localparam logic [31:0] F32_QNAN    = 32'h7FC0_0000;

    // how stage two finishes the item
    typedef enum logic [2:0] {
        K_SPEC,      // final word already known
        K_INT,       // integer magnitude, normalize and round
        K_RATIO,     // repeating-pattern quotient
        K_DBL_NORM,  // double into normal float range
        K_DBL_SUB    // double into subnormal float range
    } conv_kind_t;

    typedef struct packed {
        conv_kind_t  kind;
        logic        sign;
        logic [63:0] data;
        logic [5:0]  lz;
        logic [5:0]  sh;
        logic [7:0]  fe;
    } dec_t;

    typedef struct packed {
        logic        sign;
        logic [30:0] body;
        logic        guard;
        logic        sticky;
    } norm_t;

    function automatic logic [5:0] lzc33(input logic [32:0] v);
        logic [5:0] n;
        n = 6'd33;
        for (int i = 0; i < 33; i++) begin
            if (v[i]) n = 6'(32 - i);
        end
        return n;
    endfunction

    function automatic logic [5:0] lzc16(input logic [15:0] v);
        logic [5:0] n;
        n = 6'd16;
        for (int i = 0; i < 16; i++) begin
            if (v[i]) n = 6'(15 - i);
        end
        return n;
    endfunction

endpackage

[sv/vafc_in_if.sv]
// ----------------------------------------------------------------------------
// vafc_in_if
// Input channel: one raw attribute component per transaction.
// ----------------------------------------------------------------------------
interface vafc_in_if;
    import vafc_pkg::*;
    logic              valid;
    logic              ready;
    logic [RawW-1:0]   raw_bits;
    modport source (output valid, output raw_bits, input ready);
    modport sink   (input valid, input raw_bits, output ready);
endinterface

[sv/vafc_out_if.sv]
// ----------------------------------------------------------------------------
// vafc_out_if
// Output channel: one converted 32-bit word per transaction.
// ----------------------------------------------------------------------------
interface vafc_out_if;
    import vafc_pkg::*;
    logic               valid;
    logic               ready;
    logic [ResultW-1:0] result_bits;
    modport source (output valid, output result_bits, input ready);
    modport sink   (input valid, input result_bits, output ready);
endinterface

[sv/vertex_attribute_format_converter_unit.sv]
// ----------------------------------------------------------------------------
// vertex_attribute_format_converter_unit
// Converts a raw vertex-attribute component to float32 or unsigned integer.
// ----------------------------------------------------------------------------
//  channel | dir | payload                | transaction when
//  comp    | in  | raw_bits[63:0]         | comp.valid & comp.ready
//  conv    | out | result_bits[31:0]      | conv.valid & conv.ready
//  cfg     | in  | cfg_index, cfg_data    | cfg_we
//
//  Throughput one transaction per cycle unless conv is stalled; stages: decode,
//  normalize shift, round/pack (output register).
//  Each stage holds its item while the stage below is full and stalled;
//  comp.ready is low only when all three stages are full and conv is stalled.
//  Reset clears valid bits and loads component_type=float32, normalized=0,
//  result_format=float.
// ----------------------------------------------------------------------------
module vertex_attribute_format_converter_unit
    import vafc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    vafc_in_if.sink             comp,
    vafc_out_if.source          conv,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data
);

    comp_type_t ctype_reg;
    logic       norm_reg;
    logic       fmt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctype_reg <= CT_F32;
            norm_reg  <= 1'b0;
            fmt_reg   <= FMT_FLOAT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_COMPONENT_TYPE: ctype_reg <= comp_type_t'(cfg_data);
                REG_NORMALIZED:     norm_reg  <= cfg_data[0];
                REG_RESULT_FORMAT:  fmt_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- stall control ----------------
    logic s1_v_reg, s2_v_reg, out_v_reg;
    logic en1, en2, en3;

    assign en3 = !out_v_reg || conv.ready;
    assign en2 = !s2_v_reg || en3;
    assign en1 = !s1_v_reg || en2;
    assign comp.ready = en1;

    // ---------------- stage 1: decode ----------------
    dec_t        dec_next, s1_reg;
    logic [63:0] raw;
    logic [7:0]  u8;
    logic [15:0] u16;
    logic [31:0] u32;
    logic        n8, n16, n32;
    logic [8:0]  m8;
    logic [16:0] m16;
    logic [32:0] m32;
    logic        use_int, use_ratio, isign, rsign, rone;
    logic [32:0] imag;
    logic [63:0] rw;
    logic [15:0] ra;
    logic [10:0] dexp;
    logic [52:0] dmant;

    always_comb
    begin
        raw   = comp.raw_bits;
        u8    = raw[7:0];
        u16   = raw[15:0];
        u32   = raw[31:0];
        n8    = u8[7];
        n16   = u16[15];
        n32   = u32[31];
        m8    = n8  ? 9'h100 - {1'b0, u8} : {1'b0, u8};
        m16   = n16 ? 17'h10000 - {1'b0, u16} : {1'b0, u16};
        m32   = n32 ? 33'h1_0000_0000 - {1'b0, u32} : {1'b0, u32};
        dexp  = raw[62:52];
        dmant = {1'b1, raw[51:0]};

        use_int   = 1'b0;
        use_ratio = 1'b0;
        isign     = 1'b0;
        rsign     = 1'b0;
        rone      = 1'b0;
        imag      = '0;
        rw        = '0;
        ra        = '0;

        dec_next      = '0;
        dec_next.kind = K_SPEC;

        if (fmt_reg == FMT_UINT)
        begin
            case (ctype_reg)
                CT_S8:   dec_next.data = n8  ? 64'd0 : {56'd0, u8};
                CT_U8:   dec_next.data = {56'd0, u8};
                CT_S16:  dec_next.data = n16 ? 64'd0 : {48'd0, u16};
                CT_U16:  dec_next.data = {48'd0, u16};
                CT_S32:  dec_next.data = n32 ? 64'd0 : {32'd0, u32};
                CT_U32:  dec_next.data = {32'd0, u32};
                default: dec_next.data = '0;
            endcase
        end
        else
        begin
            case (ctype_reg)
                CT_S8:
                begin
                    if (!norm_reg)
                    begin
                        use_int = 1'b1; imag = {24'd0, m8}; isign = n8;
                    end
                    else if (n8 && m8[7])
                        dec_next.data = {32'd0, 1'b1, F32_ONE[30:0]};
                    else
                    begin
                        use_ratio = 1'b1; rsign = n8;
                        rw   = {{9{m8[6:0]}}, 1'b0};
                        ra   = {m8[6:0], 9'd0};
                        rone = (m8[6:0] == 7'h7F);
                    end
                end
                CT_U8:
                begin
                    if (!norm_reg)
                    begin
                        use_int = 1'b1; imag = {25'd0, u8};
                    end
                    else
                    begin
                        use_ratio = 1'b1;
                        rw   = {8{u8}};
                        ra   = {u8, 8'd0};
                        rone = (u8 == 8'hFF);
                    end
                end
                CT_S16:
                begin
                    if (!norm_reg)
                    begin
                        use_int = 1'b1; imag = {16'd0, m16}; isign = n16;
                    end
                    else if (n16 && m16[15])
                        dec_next.data = {32'd0, 1'b1, F32_ONE[30:0]};
                    else
                    begin
                        use_ratio = 1'b1; rsign = n16;
                        rw   = {{4{m16[14:0]}}, 4'd0};
                        ra   = {m16[14:0], 1'b0};
                        rone = (m16[14:0] == 15'h7FFF);
                    end
                end
                CT_U16:
                begin
                    if (!norm_reg)
                    begin
                        use_int = 1'b1; imag = {17'd0, u16};
                    end
                    else
                    begin
                        use_ratio = 1'b1;
                        rw   = {4{u16}};
                        ra   = u16;
                        rone = (u16 == 16'hFFFF);
                    end
                end
                CT_S32:
                begin
                    use_int = 1'b1; imag = m32; isign = n32;
                end
                CT_U32:
                begin
                    use_int = 1'b1; imag = {1'b0, u32};
                end
                CT_F32:
                    dec_next.data = {32'd0, u32};
                default:
                begin
                    // float64 narrowing
                    dec_next.sign = raw[63];
                    if (dexp == 11'h7FF)
                    begin
                        if (raw[51:0] == 52'd0)
                            dec_next.data = {32'd0, raw[63], F32_INF[30:0]};
                        else
                            dec_next.data = {32'd0, raw[63],
                                             F32_QNAN[30:0] | {8'd0, raw[51:29]}};
                    end
                    else if (dexp == 11'd0 || dexp <= 11'd871)
                        dec_next.data = {32'd0, raw[63], 31'd0};
                    else if (dexp >= 11'd1151)
                        dec_next.data = {32'd0, raw[63], F32_INF[30:0]};
                    else if (dexp >= 11'd897)
                    begin
                        dec_next.kind = K_DBL_NORM;
                        dec_next.data = {11'd0, dmant};
                        dec_next.fe   = 8'(dexp - 11'd896);
                    end
                    else
                    begin
                        // shift of 30..54 into the subnormal range
                        dec_next.kind = K_DBL_SUB;
                        dec_next.data = {11'd0, dmant};
                        dec_next.sh   = 6'(11'd926 - dexp);
                    end
                end
            endcase

            if (use_int && imag != 33'd0)
            begin
                dec_next.kind = K_INT;
                dec_next.sign = isign;
                dec_next.data = {31'd0, imag};
                dec_next.lz   = lzc33(imag);
            end
            if (use_ratio && ra != 16'd0)
            begin
                if (rone)
                    dec_next.data = {32'd0, rsign, F32_ONE[30:0]};
                else
                begin
                    // n/(2^k-1) is n repeated every k bits: never exact, so
                    // rounding only looks at the guard bit
                    dec_next.kind = K_RATIO;
                    dec_next.sign = rsign;
                    dec_next.data = rw;
                    dec_next.lz   = lzc16(ra);
                end
            end
        end
    end

    // ---------------- stage 2: normalize ----------------
    norm_t        norm_next, s2_reg;
    logic [32:0]  ish;
    logic [63:0]  wsh;
    logic [107:0] tsh;

    always_comb
    begin
        ish = s1_reg.data[32:0] << s1_reg.lz;
        wsh = s1_reg.data << s1_reg.lz;
        tsh = {s1_reg.data[52:0], 55'd0} >> s1_reg.sh;
        norm_next.sign = s1_reg.sign;
        case (s1_reg.kind)
            K_INT:
            begin
                norm_next.body   = {8'(9'd159 - {3'd0, s1_reg.lz}), ish[31:9]};
                norm_next.guard  = ish[8];
                norm_next.sticky = |ish[7:0];
            end
            K_RATIO:
            begin
                norm_next.body   = {8'(9'd126 - {3'd0, s1_reg.lz}), wsh[62:40]};
                norm_next.guard  = wsh[39];
                norm_next.sticky = 1'b1;
            end
            K_DBL_NORM:
            begin
                norm_next.body   = {s1_reg.fe, s1_reg.data[51:29]};
                norm_next.guard  = s1_reg.data[28];
                norm_next.sticky = |s1_reg.data[27:0];
            end
            K_DBL_SUB:
            begin
                norm_next.body   = {8'd0, tsh[77:55]};
                norm_next.guard  = tsh[54];
                norm_next.sticky = |tsh[53:0];
            end
            default:
            begin
                norm_next.sign   = s1_reg.data[31];
                norm_next.body   = s1_reg.data[30:0];
                norm_next.guard  = 1'b0;
                norm_next.sticky = 1'b0;
            end
        endcase
    end

    // ---------------- stage 3: round and pack ----------------
    // mantissa carry runs into the exponent field; 255 gives infinity
    logic [31:0] out_next, out_reg;
    logic        rnd;

    always_comb
    begin
        rnd      = s2_reg.guard && (s2_reg.sticky || s2_reg.body[0]);
        out_next = {s2_reg.sign, s2_reg.body + {30'd0, rnd}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (en1) s1_v_reg  <= comp.valid;
            if (en2) s2_v_reg  <= s1_v_reg;
            if (en3) out_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1) s1_reg  <= dec_next;
        if (en2) s2_reg  <= norm_next;
        if (en3) out_reg <= out_next;
    end

    assign conv.valid       = out_v_reg;
    assign conv.result_bits = out_reg;

endmodule

[sv/vafc_checker.sv]
// ----------------------------------------------------------------------------
// vafc_checker
// Port-level assertions for the converter, bound to the top level.
// ----------------------------------------------------------------------------
module vafc_checker
    import vafc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [ResultW-1:0] out_bits
);

    // held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_bits))
        else $error("stalled result changed");

    // an offered transaction is not withdrawn while it waits
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("offered transaction withdrawn");

    // input back-pressure only while the output is stalled
    a_full_only: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output back-pressure");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid straight out of reset");

endmodule

bind vertex_attribute_format_converter_unit vafc_checker u_vafc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (comp.valid),
    .in_ready  (comp.ready),
    .out_valid (conv.valid),
    .out_ready (conv.ready),
    .out_bits  (conv.result_bits)
);
